FILE: src/mqsb_pkg.sv
package mqsb_pkg;

  // Field widths of the request and response channels.
  localparam int CMD_W    = 1;
  localparam int QNUM_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // Operation codes.
  localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

FILE: src/mqsb_if.sv
// Request channel: one enqueue or dequeue per request.
interface mqsb_req_if import mqsb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [QNUM_W-1:0]   queue_num;
  data_t               push_value;

  modport source (output valid, cmd, queue_num, push_value, input ready);
  modport sink (input valid, cmd, queue_num, push_value, output ready);
endinterface

// Response channel: one response per request.
interface mqsb_rsp_if import mqsb_pkg::*; ();
  logic                valid;
  logic                ready;
  data_t               pop_value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, pop_value, status, input ready);
  modport sink (input valid, pop_value, status, output ready);
endinterface

FILE: src/multi_queue_shared_buffer_top.sv
// Several FIFO queues that share one pool of QUEUE_SLOTS data slots.
// The req channel carries an enqueue (cmd 0) or a dequeue (cmd 1) on a queue
// numbered from 1; push_value is stored on enqueue. The rsp channel returns one
// response per request: pop_value (zero unless a dequeue succeeded) and a
// status of ok, full (no free slot, or bad queue on enqueue) or empty.
// Slots are chained by a link memory and the data sits in a data memory, both
// synchronous with registered reads. A request is taken in the idle state,
// which issues the memory reads; the exec state then does the link update and
// write-back and loads the response register. The read-then-write of the link
// memory sets this split into an idle and an exec state. A new request is
// taken while a response waits; if the response register is still full in the
// exec state, the block holds there until the receiver takes it.
// Reset empties every queue and puts all slots on the free list in order at
// once: a fill count marks slots never handed out, whose links read as the
// next slot, so no clearing pass over the memories is needed.
module multi_queue_shared_buffer_top
  import mqsb_pkg::*;
#(
  parameter int QUEUE_SLOTS = 16,
  parameter int NUM_QUEUES  = 4
) (
  input  logic      clk,
  input  logic      rst,
  mqsb_req_if.sink  req,
  mqsb_rsp_if.source rsp
);

  // Pointers hold QUEUE_SLOTS as the null value.
  localparam int PW  = $clog2(QUEUE_SLOTS + 1);
  localparam int IW  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  // Only queues reachable through the queue number field get storage.
  localparam int QLIM = (1 << QNUM_W) - 1;
  localparam int NQ   = (NUM_QUEUES < QLIM) ? NUM_QUEUES : QLIM;
  localparam int QIW  = (NQ > 1) ? $clog2(NQ) : 1;
  localparam logic [PW-1:0]     NULL_PTR = PW'(QUEUE_SLOTS);
  localparam logic [QNUM_W-1:0] QMAX     = QNUM_W'(NQ);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;

  // Queue pointers, free list head and the count of slots ever handed out.
  logic [PW-1:0] head [NQ];
  logic [PW-1:0] tail [NQ];
  logic [PW-1:0] free_head;
  logic [PW-1:0] fresh;

  // Memories.
  logic [PW-1:0] link_mem [QUEUE_SLOTS];
  data_t         data_mem [QUEUE_SLOTS];
  logic [PW-1:0] link_rd;
  data_t         data_rd;

  // Request captured at acceptance.
  logic [CMD_W-1:0] op;
  logic [QIW-1:0]   qi;
  logic             q_ok;
  data_t            wdata;
  logic [PW-1:0]    slot;

  // Response register.
  logic                out_valid;
  data_t               out_pop;
  logic [STATUS_W-1:0] out_status;

  logic                accept;
  logic                commit;
  logic [QNUM_W-1:0]   qsel;
  logic [QIW-1:0]      qsel_idx;
  logic                qsel_ok;
  logic [PW-1:0]       slot_sel;
  logic                slot_ok;
  logic                act;
  logic [PW-1:0]       link_val;
  logic                lw_en;
  logic [IW-1:0]       lw_addr;
  logic [PW-1:0]       lw_data;
  logic [STATUS_W-1:0] st_calc;

  assign req.ready      = (state == S_IDLE);
  assign accept         = req.valid && req.ready;
  assign commit         = (state == S_EXEC) && (!out_valid || rsp.ready);
  assign rsp.valid      = out_valid;
  assign rsp.pop_value  = out_pop;
  assign rsp.status     = out_status;

  // Decode the queue number and choose the slot to touch.
  always_comb begin
    qsel     = req.queue_num - QNUM_W'(1);
    qsel_idx = qsel[QIW-1:0];
    qsel_ok  = (req.queue_num != '0) && (req.queue_num <= QMAX);
    if (req.cmd == CMD_DEQ) begin
      slot_sel = head[qsel_idx];
    end else begin
      slot_sel = free_head;
    end
  end

  // Work out the write-back from the captured request and the read data.
  always_comb begin
    slot_ok = (slot < NULL_PTR);
    act     = q_ok && slot_ok;
    // A slot never handed out still links to the slot after it.
    if (slot >= fresh) begin
      link_val = slot + PW'(1);
    end else begin
      link_val = link_rd;
    end
    if (act) begin
      st_calc = ST_OK;
    end else if (op == CMD_DEQ) begin
      st_calc = ST_EMPTY;
    end else begin
      st_calc = ST_FULL;
    end
    lw_en   = 1'b0;
    lw_addr = slot[IW-1:0];
    lw_data = free_head;
    if (commit && act) begin
      if (op == CMD_DEQ) begin
        lw_en = 1'b1;
      end else if (head[qi] < NULL_PTR) begin
        lw_en   = 1'b1;
        lw_addr = tail[qi][IW-1:0];
        lw_data = slot;
      end
    end
  end

  // Link memory: one read port, one write port.
  always_ff @(posedge clk) begin
    if (accept) begin
      link_rd <= link_mem[slot_sel[IW-1:0]];
    end
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
  end

  // Data memory: written on a successful enqueue, read for a dequeue.
  always_ff @(posedge clk) begin
    if (accept) begin
      data_rd <= data_mem[slot_sel[IW-1:0]];
    end
    if (commit && act && (op == CMD_ENQ)) begin
      data_mem[slot[IW-1:0]] <= wdata;
    end
  end

  // Capture the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= req.cmd;
      qi    <= qsel_idx;
      q_ok  <= qsel_ok;
      wdata <= req.push_value;
      slot  <= slot_sel;
    end
  end

  // Control state, queue pointers and free list.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      fresh     <= '0;
      for (int i = 0; i < NQ; i++) begin
        head[i] <= NULL_PTR;
        tail[i] <= NULL_PTR;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
            if (act) begin
              if (op == CMD_ENQ) begin
                free_head <= link_val;
                if (slot >= fresh) begin
                  fresh <= fresh + PW'(1);
                end
                if (!(head[qi] < NULL_PTR)) begin
                  head[qi] <= slot;
                end
                tail[qi] <= slot;
              end else begin
                // The tail slot is the last one, so its link is not needed.
                if (slot == tail[qi]) begin
                  head[qi] <= NULL_PTR;
                end else begin
                  head[qi] <= link_val;
                end
                free_head <= slot;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status <= st_calc;
      if (act && (op == CMD_DEQ)) begin
        out_pop <= data_rd;
      end else begin
        out_pop <= '0;
      end
    end
  end

`ifndef SYNTH
  // An accepted request moves to the write-back cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted request did not reach write-back");

  // A write-back always leaves a response waiting.
  a_commit_rsp: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp.valid)
    else $error("write-back without a response");

  // Failed operations return a zero data word.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.pop_value == '0))
    else $error("nonzero data on a failed operation");

  // The fill count never passes the number of slots.
  a_fresh_range: assert property (@(posedge clk) disable iff (rst)
    fresh <= NULL_PTR)
    else $error("fill count out of range");
`endif

endmodule
